// ===== src/sldp_pkg.sv =====
`timescale 1ns / 1ps

package sldp_pkg;

  localparam int unsigned SYM_W = 7;
  localparam int unsigned CMD_W = 3;

  localparam int unsigned DEF_SYMBOL_COUNT        = 128;
  localparam int unsigned DEF_WEIGHT_SYMBOL_COUNT = 128;
  localparam int unsigned DEF_NEURON_COUNT        = 128;

  // Results that may be outstanding between input acceptance and output delivery.
  localparam int unsigned RES_FIFO_DEPTH = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_MUL  = 3'd0,
    CMD_WR_ADD  = 3'd1,
    CMD_WR_BIAS = 3'd2,
    CMD_WR_RELU = 3'd3,
    CMD_ACC     = 3'd4
  } cmd_t;

endpackage

// ===== src/sldp_ram.sv =====
`timescale 1ns / 1ps

module sldp_ram #(
  parameter int unsigned DATA_W = 7,
  parameter int unsigned ADDR_W = 14
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data_r
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_r [DEPTH];

  // Read-first: a read and a write of the same entry in one cycle returns the old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

// ===== src/sldp_fifo.sv =====
`timescale 1ns / 1ps

module sldp_fifo #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned DATA_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/symbolic_lut_dot_product_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// in        in   in_valid / in_stall  command, first/second/neuron index, table_value, last_term
// out       out  out_valid/ out_stall result_symbol
// cfg       in   cfg_valid/ cfg_ready relu_enable
//
// A transaction is accepted each cycle while in_stall is low; results pass stages B-E to a FIFO.
// The running symbol loops from the add-table read data straight into the next term's
// add-table read address, so consecutive terms issue in consecutive cycles.
// in_stall rises while 8 results are outstanding (in flight or waiting on out_stall).
// Reset is synchronous and clears the sum and the control state; tables keep their contents.
module symbolic_lut_dot_product_top #(
  parameter int unsigned SYMBOL_COUNT        = sldp_pkg::DEF_SYMBOL_COUNT,
  parameter int unsigned WEIGHT_SYMBOL_COUNT = sldp_pkg::DEF_WEIGHT_SYMBOL_COUNT,
  parameter int unsigned NEURON_COUNT        = sldp_pkg::DEF_NEURON_COUNT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [sldp_pkg::CMD_W-1:0] in_command,
  input  logic [sldp_pkg::SYM_W-1:0] in_first_index,
  input  logic [sldp_pkg::SYM_W-1:0] in_second_index,
  input  logic [sldp_pkg::SYM_W-1:0] in_neuron_index,
  input  logic [sldp_pkg::SYM_W-1:0] in_table_value,
  input  logic                       in_last_term,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [sldp_pkg::SYM_W-1:0] out_result_symbol,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_relu_enable
);

  import sldp_pkg::*;

  localparam int unsigned MAX_IDX  = 2 ** SYM_W;
  localparam int unsigned SYM_ROWS = (SYMBOL_COUNT < MAX_IDX) ? SYMBOL_COUNT : MAX_IDX;
  localparam int unsigned WGT_ROWS =
      (WEIGHT_SYMBOL_COUNT < MAX_IDX) ? WEIGHT_SYMBOL_COUNT : MAX_IDX;
  localparam int unsigned NRN_ROWS = (NEURON_COUNT < MAX_IDX) ? NEURON_COUNT : MAX_IDX;
  localparam int unsigned SW = $clog2(SYM_ROWS);
  localparam int unsigned WW = $clog2(WGT_ROWS);
  localparam int unsigned NW = (NRN_ROWS > 1) ? $clog2(NRN_ROWS) : 1;
  localparam int unsigned CNT_W = $clog2(RES_FIFO_DEPTH + 1);

  // Input acceptance
  logic in_acc;
  cmd_t in_cmd;

  // Stage B
  logic             b_vld_r;
  cmd_t             b_cmd_r;
  logic [SYM_W-1:0] b_a_r, b_b_r, b_n_r, b_v_r;
  logic             b_last_r;

  // Stage C
  logic             c_vld_r;
  cmd_t             c_cmd_r;
  logic [SYM_W-1:0] c_a_r, c_n_r, c_v_r, c_prod_r;
  logic             c_last_r, c_add_r, c_add_ok_r;

  // Stage D
  logic             d_res_r, d_relu_wr_r, d_bias_ok_r;
  logic [SYM_W-1:0] d_a_r, d_v_r;

  // Stage E
  logic             e_res_r, e_relu_ok_r;
  logic [SYM_W-1:0] e_sym_r;

  // Sum state and control
  logic [SYM_W-1:0] running_r;
  logic             started_r;
  logic             relu_en_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Table read data
  logic [SYM_W-1:0] mul_rdata, add_rdata, bias_rdata, relu_rdata;

  // Combinational
  logic             mul_wr_en, add_wr_en, bias_wr_en;
  logic             mul_ok_b, add_ok_b, bias_ok_c, relu_ok_d;
  logic [SYM_W-1:0] prod_b, run_cur, run_new_c, sym_d, result_e;
  logic             started_cur, c_term, res_pop;

  assign in_acc    = in_valid && !in_stall;
  assign in_cmd    = cmd_t'(in_command);
  assign in_stall  = (cnt_r == CNT_W'(RES_FIFO_DEPTH));
  assign cfg_ready = 1'b1;
  assign res_pop   = out_valid && !out_stall;

  // Multiply table: read and written in the accept cycle.
  assign mul_wr_en = in_acc && (in_cmd == CMD_WR_MUL)
                     && (32'(in_first_index) < SYMBOL_COUNT)
                     && (32'(in_second_index) < WEIGHT_SYMBOL_COUNT);

  sldp_ram #(.DATA_W(SYM_W), .ADDR_W(SW + WW)) u_mul_ram (
    .clk       (clk),
    .wr_en     (mul_wr_en),
    .wr_addr   ({in_first_index[SW-1:0], in_second_index[WW-1:0]}),
    .wr_data   (in_table_value),
    .rd_addr   ({in_first_index[SW-1:0], in_second_index[WW-1:0]}),
    .rd_data_r (mul_rdata)
  );

  // Stage B: product available; add-table lookup with the forwarded running symbol.
  assign mul_ok_b = (32'(b_a_r) < SYMBOL_COUNT) && (32'(b_b_r) < WEIGHT_SYMBOL_COUNT);
  assign prod_b   = mul_ok_b ? mul_rdata : '0;
  assign c_term   = c_vld_r && (c_cmd_r == CMD_ACC);
  assign run_new_c = c_add_r ? (c_add_ok_r ? add_rdata : '0) : c_prod_r;

  // A term in stage C has not yet reached the sum registers, so its result is forwarded.
  always_comb begin
    if (c_term) begin
      started_cur = !c_last_r;
      run_cur     = c_last_r ? '0 : run_new_c;
    end else begin
      started_cur = started_r;
      run_cur     = running_r;
    end
  end

  assign add_ok_b  = (32'(run_cur) < SYMBOL_COUNT) && (32'(prod_b) < SYMBOL_COUNT);
  assign add_wr_en = b_vld_r && (b_cmd_r == CMD_WR_ADD)
                     && (32'(b_a_r) < SYMBOL_COUNT) && (32'(b_b_r) < SYMBOL_COUNT);

  sldp_ram #(.DATA_W(SYM_W), .ADDR_W(SW + SW)) u_add_ram (
    .clk       (clk),
    .wr_en     (add_wr_en),
    .wr_addr   ({b_a_r[SW-1:0], b_b_r[SW-1:0]}),
    .wr_data   (b_v_r),
    .rd_addr   ({run_cur[SW-1:0], prod_b[SW-1:0]}),
    .rd_data_r (add_rdata)
  );

  // Stage C: new running symbol; bias lookup on a finishing term.
  assign bias_ok_c  = (32'(run_new_c) < SYMBOL_COUNT) && (32'(c_n_r) < NEURON_COUNT);
  assign bias_wr_en = c_vld_r && (c_cmd_r == CMD_WR_BIAS)
                      && (32'(c_a_r) < SYMBOL_COUNT) && (32'(c_n_r) < NEURON_COUNT);

  sldp_ram #(.DATA_W(SYM_W), .ADDR_W(SW + NW)) u_bias_ram (
    .clk       (clk),
    .wr_en     (bias_wr_en),
    .wr_addr   ({c_a_r[SW-1:0], c_n_r[NW-1:0]}),
    .wr_data   (c_v_r),
    .rd_addr   ({run_new_c[SW-1:0], c_n_r[NW-1:0]}),
    .rd_data_r (bias_rdata)
  );

  // Stage D: biased symbol; relu lookup.
  assign sym_d     = d_bias_ok_r ? bias_rdata : '0;
  assign relu_ok_d = (32'(sym_d) < SYMBOL_COUNT);

  sldp_ram #(.DATA_W(SYM_W), .ADDR_W(SW)) u_relu_ram (
    .clk       (clk),
    .wr_en     (d_relu_wr_r),
    .wr_addr   (d_a_r[SW-1:0]),
    .wr_data   (d_v_r),
    .rd_addr   (sym_d[SW-1:0]),
    .rd_data_r (relu_rdata)
  );

  // Stage E: final symbol into the result queue.
  assign result_e = relu_en_r ? (e_relu_ok_r ? relu_rdata : '0) : e_sym_r;

  sldp_fifo #(.DEPTH(RES_FIFO_DEPTH), .DATA_W(SYM_W)) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (e_res_r),
    .push_data (result_e),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_result_symbol)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && (in_cmd == CMD_ACC) && in_last_term) begin
      cnt_nxt = cnt_nxt + CNT_W'(1);
    end
    if (res_pop) begin
      cnt_nxt = cnt_nxt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_res_r     <= 1'b0;
      d_relu_wr_r <= 1'b0;
      e_res_r     <= 1'b0;
      running_r   <= '0;
      started_r   <= 1'b0;
      relu_en_r   <= 1'b0;
      cnt_r       <= '0;
    end else begin
      b_vld_r     <= in_acc;
      c_vld_r     <= b_vld_r;
      d_res_r     <= c_term && c_last_r;
      d_relu_wr_r <= c_vld_r && (c_cmd_r == CMD_WR_RELU) && (32'(c_a_r) < SYMBOL_COUNT);
      e_res_r     <= d_res_r;
      cnt_r       <= cnt_nxt;
      if (c_term) begin
        running_r <= c_last_r ? '0 : run_new_c;
        started_r <= !c_last_r;
      end
      if (cfg_valid && cfg_ready) begin
        relu_en_r <= cfg_relu_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_cmd_r     <= in_cmd;
    b_a_r       <= in_first_index;
    b_b_r       <= in_second_index;
    b_n_r       <= in_neuron_index;
    b_v_r       <= in_table_value;
    b_last_r    <= in_last_term;
    c_cmd_r     <= b_cmd_r;
    c_a_r       <= b_a_r;
    c_n_r       <= b_n_r;
    c_v_r       <= b_v_r;
    c_last_r    <= b_last_r;
    c_prod_r    <= prod_b;
    c_add_r     <= started_cur;
    c_add_ok_r  <= add_ok_b;
    d_a_r       <= c_a_r;
    d_v_r       <= c_v_r;
    d_bias_ok_r <= bias_ok_c;
    e_sym_r     <= sym_d;
    e_relu_ok_r <= relu_ok_d;
  end

  a_last_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_ACC) && in_last_term) |-> ##4 e_res_r)
    else $error("finishing term did not reach the result queue");

  a_result_is_counted: assert property (@(posedge clk) disable iff (!rst_n)
    e_res_r |-> (cnt_r != '0))
    else $error("result pushed without an outstanding count");

  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (c_term && c_last_r) |=> !started_r)
    else $error("sum not cleared after a finishing term");

endmodule
